[hdl/sme_pkg.sv]
package sme_pkg;

  localparam int STACK_DEPTH   = 1024;
  localparam int DATA_DEPTH    = 1024;
  localparam int PROGRAM_DEPTH = 1024;

  localparam int WORD_W = 32;
  localparam int OP_W   = 4;
  localparam int ST_W   = 3;
  localparam int PC_W   = 10;
  localparam int TGT_W  = 10;

  // The count must be able to hold STACK_DEPTH itself.
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int DA_W  = $clog2(DATA_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_LDC = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_JMP = 4'd6,
    OP_BR  = 4'd7,
    OP_RET = 4'd8
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BADADDR = 3'd4
  } status_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_IDLE
  } clr_state_t;

  typedef struct packed {
    logic            busy;
    logic            we;
    logic [DA_W-1:0] addr;
  } clr_t;

  // Architectural state as seen by the execute logic. top and second are
  // the effective values, already selected from a register or a RAM output.
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [CNT_W-1:0]  cnt;
    status_t           mstat;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] second;
  } mach_t;

  typedef struct packed {
    mach_t             nxt;
    logic              top_sel;
    logic              second_sel;
    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr;
    logic [WORD_W-1:0] stk_wdata;
    logic              stk_re;
    logic [SA_W-1:0]   stk_raddr;
    logic              dat_we;
    logic [DA_W-1:0]   dat_waddr;
    logic [WORD_W-1:0] dat_wdata;
    logic              dat_re;
    logic [DA_W-1:0]   dat_raddr;
    logic [WORD_W-1:0] out_top;
  } exec_t;

endpackage

[hdl/stack_machine_execute.sv]
// Executes one stack-machine instruction per transaction and returns one
// result transaction for each, in the cycle after the instruction is accepted.
// A new instruction can be accepted in every cycle that in_stall is low: the
// top two stack entries sit in registers, deeper entries in a registered-read
// stack RAM, and the data memory is a registered-read RAM whose read data
// feeds the top of stack directly, so throughput is one instruction per clock
// while in_stall is low. in_stall is high while the data memory is swept to
// zero after reset, one word per cycle, until every word is cleared, and when
// the result register is full and stalled. Once the machine halts or faults,
// later instructions leave all state unchanged and each result repeats the
// held program counter, status and top of stack.
module stack_machine_execute import sme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [WORD_W-1:0] operand,
  input  logic [TGT_W-1:0]         jump_target,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PC_W-1:0]          next_pc,
  output logic [ST_W-1:0]          status,
  output logic signed [WORD_W-1:0] top_value
);

  clr_t              clr;
  exec_t             ex;
  mach_t             cur;
  logic              accept;

  logic [PC_W-1:0]   pc;
  logic [CNT_W-1:0]  cnt;
  status_t           mstat;
  logic [WORD_W-1:0] top_reg;
  logic              top_sel;
  logic [WORD_W-1:0] second_reg;
  logic              second_sel;

  logic [PC_W-1:0]   out_pc;
  status_t           out_status;
  logic [WORD_W-1:0] out_top;
  logic              out_tsel;

  logic [WORD_W-1:0] stk_rdata;
  logic [WORD_W-1:0] dat_rdata;
  logic              dat_we;
  logic [DA_W-1:0]   dat_waddr;
  logic [WORD_W-1:0] dat_wdata;

  sme_clear u_clear (
    .clk (clk),
    .rst (rst),
    .clr (clr)
  );

  assign in_stall = clr.busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cur.pc     = pc;
  assign cur.cnt    = cnt;
  assign cur.mstat  = mstat;
  assign cur.top    = top_sel ? dat_rdata : top_reg;
  assign cur.second = second_sel ? stk_rdata : second_reg;

  sme_exec u_exec (
    .opcode      (opcode),
    .operand     ($unsigned(operand)),
    .jump_target (jump_target),
    .cur         (cur),
    .ex          (ex)
  );

  sme_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (accept && ex.stk_we),
    .waddr (ex.stk_waddr),
    .wdata (ex.stk_wdata),
    .re    (accept && ex.stk_re),
    .raddr (ex.stk_raddr),
    .rdata (stk_rdata)
  );

  assign dat_we    = clr.we || (accept && ex.dat_we);
  assign dat_waddr = clr.busy ? clr.addr : ex.dat_waddr;
  assign dat_wdata = clr.busy ? '0 : ex.dat_wdata;

  sme_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .re    (accept && ex.dat_re),
    .raddr (ex.dat_raddr),
    .rdata (dat_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      cnt        <= '0;
      mstat      <= ST_RUN;
      top_sel    <= 1'b0;
      second_sel <= 1'b0;
    end else if (accept) begin
      pc         <= ex.nxt.pc;
      cnt        <= ex.nxt.cnt;
      mstat      <= ex.nxt.mstat;
      top_sel    <= ex.top_sel;
      second_sel <= ex.second_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_reg    <= ex.nxt.top;
      second_reg <= ex.nxt.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_tsel  <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
      out_tsel  <= ex.top_sel;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pc     <= ex.nxt.pc;
      out_status <= ex.nxt.mstat;
      out_top    <= ex.out_top;
    end
  end

  // A load result is taken straight from the data RAM output, which holds
  // until the next load is accepted.
  assign next_pc   = out_pc;
  assign status    = out_status;
  assign top_value = $signed(out_tsel ? dat_rdata : out_top);

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(mstat) != ST_RUN) |->
      ($stable(pc) && $stable(cnt) && $stable(mstat)))
    else $error("state changed after a halt or a fault");

  a_stack_port: assert property (@(posedge clk) disable iff (rst)
    (accept && ex.stk_we) |-> !ex.stk_re)
    else $error("stack RAM read and written by the same instruction");

  a_load_path: assert property (@(posedge clk) disable iff (rst)
    (accept && ex.dat_re) |=> (out_valid && out_tsel))
    else $error("load result not routed from the data RAM");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (accept && ex.nxt.cnt == '0) |=> (out_valid && top_value == '0))
    else $error("nonzero top reported for an empty stack");

endmodule

[hdl/sme_ram.sv]
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sme_clear.sv]
module sme_clear import sme_pkg::*; (
  input  logic clk,
  input  logic rst,
  output clr_t clr
);

  clr_state_t      state;
  clr_state_t      state_next;
  logic [DA_W-1:0] cnt;
  logic [DA_W-1:0] cnt_next;
  logic            last;

  assign last = (cnt == DA_W'(DATA_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR_SWEEP;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CLR_SWEEP: begin
        if (last) begin
          state_next = CLR_IDLE;
        end
      end
      CLR_IDLE: state_next = CLR_IDLE;
      default:  state_next = CLR_IDLE;
    endcase
  end

  always_comb begin
    clr.busy = 1'b0;
    clr.we   = 1'b0;
    clr.addr = cnt;
    cnt_next = cnt;
    unique case (state)
      CLR_SWEEP: begin
        clr.busy = 1'b1;
        clr.we   = 1'b1;
        cnt_next = cnt + DA_W'(1);
      end
      CLR_IDLE: begin
        clr.busy = 1'b0;
      end
      default: begin
        clr.busy = 1'b0;
      end
    endcase
  end

endmodule

[hdl/sme_exec.sv]
module sme_exec import sme_pkg::*; (
  input  logic [OP_W-1:0]    opcode,
  input  logic [WORD_W-1:0]  operand,
  input  logic [TGT_W-1:0]   jump_target,
  input  mach_t              cur,
  output exec_t              ex
);

  logic [31:0]       pc_inc;
  logic [PC_W-1:0]   pc_seq;
  logic              tgt_bad;
  logic              addr_bad;
  logic              full;
  logic [WORD_W-1:0] alu;
  status_t           st;

  assign pc_inc   = 32'(cur.pc) + 32'd1;
  assign pc_seq   = (pc_inc >= 32'(PROGRAM_DEPTH)) ? '0 : PC_W'(pc_inc);
  assign tgt_bad  = (32'(jump_target) >= 32'(PROGRAM_DEPTH));
  assign addr_bad = (operand >= 32'(DATA_DEPTH));
  assign full     = (cur.cnt >= CNT_W'(STACK_DEPTH));

  always_comb begin
    case (opcode_t'(opcode))
      OP_ADD:  alu = cur.top + cur.second;
      OP_SUB:  alu = cur.top - cur.second;
      default: begin
        if ($signed(cur.top) > $signed(cur.second)) begin
          alu = 32'd1;
        end else if ($signed(cur.top) < $signed(cur.second)) begin
          alu = '1;
        end else begin
          alu = '0;
        end
      end
    endcase
  end

  always_comb begin
    ex            = '0;
    ex.nxt        = cur;
    ex.stk_waddr  = SA_W'(cur.cnt - CNT_W'(2));
    ex.stk_wdata  = cur.second;
    ex.stk_raddr  = SA_W'(cur.cnt - CNT_W'(3));
    ex.dat_waddr  = operand[DA_W-1:0];
    ex.dat_wdata  = cur.top;
    ex.dat_raddr  = operand[DA_W-1:0];
    st            = ST_RUN;

    if (cur.mstat == ST_RUN) begin
      ex.nxt.pc = pc_seq;
      unique case (opcode_t'(opcode)) inside
        OP_LD, OP_LDC: begin
          if (full) begin
            st = ST_OVER;
          end else if (opcode_t'(opcode) == OP_LD && addr_bad) begin
            st = ST_BADADDR;
          end else begin
            // Push: the old second spills to the RAM, the old top moves down.
            ex.stk_we     = (cur.cnt >= CNT_W'(2));
            ex.nxt.second = cur.top;
            ex.nxt.cnt    = cur.cnt + CNT_W'(1);
            if (opcode_t'(opcode) == OP_LD) begin
              ex.dat_re  = 1'b1;
              ex.top_sel = 1'b1;
            end else begin
              ex.nxt.top = operand;
            end
          end
        end
        OP_ST: begin
          if (cur.cnt == '0) begin
            st = ST_UNDER;
          end else if (addr_bad) begin
            st = ST_BADADDR;
          end else begin
            ex.dat_we     = 1'b1;
            ex.nxt.top    = cur.second;
            ex.stk_re     = (cur.cnt >= CNT_W'(3));
            ex.second_sel = (cur.cnt >= CNT_W'(3));
            ex.nxt.cnt    = cur.cnt - CNT_W'(1);
          end
        end
        OP_ADD, OP_SUB, OP_CMP: begin
          if (cur.cnt < CNT_W'(2)) begin
            st = ST_UNDER;
          end else begin
            ex.nxt.top    = alu;
            ex.stk_re     = (cur.cnt >= CNT_W'(3));
            ex.second_sel = (cur.cnt >= CNT_W'(3));
            ex.nxt.cnt    = cur.cnt - CNT_W'(1);
          end
        end
        OP_JMP: begin
          if (tgt_bad) begin
            st = ST_BADADDR;
          end else begin
            ex.nxt.pc = PC_W'(jump_target);
          end
        end
        OP_BR: begin
          if (cur.cnt == '0) begin
            st = ST_UNDER;
          end else if (cur.top != '0) begin
            if (tgt_bad) begin
              st = ST_BADADDR;
            end else begin
              ex.nxt.pc = PC_W'(jump_target);
            end
          end
        end
        OP_RET: begin
          if (cur.cnt == '0) begin
            st = ST_UNDER;
          end else begin
            st = ST_HALT;
          end
        end
        default: begin
        end
      endcase

      if (st != ST_RUN) begin
        ex.nxt.pc = cur.pc;
      end
      ex.nxt.mstat = st;
    end

    ex.out_top = (ex.nxt.cnt == '0) ? '0 : ex.nxt.top;
  end

endmodule
